>>> sv/ltt_pkg.sv
// Shared constants, codes and status types of the looping timeline tracker.
// Used by the interfaces, the serial arithmetic units and the top level.
`default_nettype none

package ltt_pkg;

	localparam int TIME_BITS_DEF = 40;

	// Register and field widths fixed by the register map and item format.
	localparam int CFG_W     = 25;
	localparam int CFG_IDX_W = 2;
	localparam int DUR_W     = 25;
	localparam int LOOPS_W   = 17;
	localparam int DMAG_W    = 24;
	localparam int NMAG_W    = 16;
	localparam int IDX_W     = 16;
	localparam int CMD_W     = 3;
	localparam int RUN_W     = 2;
	localparam int LIM_W     = DMAG_W + NMAG_W;
	localparam int MUL_B_W   = IDX_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOPS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKWARD = 2'd2;

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESUME = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd5;

	localparam logic [RUN_W-1:0] RUN_STOPPED = 2'd0;
	localparam logic [RUN_W-1:0] RUN_PAUSED  = 2'd1;
	localparam logic [RUN_W-1:0] RUN_RUNNING = 2'd2;

	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

`default_nettype wire

>>> sv/ltt_if.sv
// Valid/ready channels of the looping timeline tracker: command items in,
// timeline report items out. Widths come from ltt_pkg.
`default_nettype none

interface ltt_cmd_if #(
	parameter int TIME_BITS = ltt_pkg::TIME_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [ltt_pkg::CMD_W-1:0]   command;
	logic [TIME_BITS-1:0]        time_value;

	modport source(output valid, command, time_value, input ready);
	modport sink(input valid, command, time_value, output ready);
endinterface

interface ltt_res_if #(
	parameter int TIME_BITS = ltt_pkg::TIME_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [ltt_pkg::RUN_W-1:0]   run_state;
	logic [TIME_BITS-1:0]        total_time;
	logic [TIME_BITS-1:0]        loop_time;
	logic [ltt_pkg::IDX_W-1:0]   loop_index;
	logic                        loop_changed;
	logic                        finished;

	modport source(output valid, run_state, total_time, loop_time, loop_index,
		loop_changed, finished, input ready);
	modport sink(input valid, run_state, total_time, loop_time, loop_index,
		loop_changed, finished, output ready);
endinterface

`default_nettype wire

>>> sv/looping_timeline_tracker.sv
// Top level of the looping timeline tracker: register file, command sequencer
// and timeline state. Uses ltt_pkg, ltt_if, ltt_serial_mul and ltt_serial_div.
//
//   channel   dir   handshake      payload
//   cmd       in    valid/ready    command, time_value
//   res       out   valid/ready    run_state, total_time, loop_time,
//                                  loop_index, loop_changed, finished
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// One item is worked at a time. Every item first forms duration times loop
// count in the serial multiplier. Moving the time with a positive duration
// runs the serial divider, one quotient bit a cycle; a forward stop adds a
// second multiply.
// Reset is asynchronous and returns the timeline and registers to defaults.
// The next item is taken while a report still waits in the output register.
`default_nettype none

module looping_timeline_tracker #(
	parameter int TIME_BITS = ltt_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ltt_cmd_if.sink                         cmd,
	ltt_res_if.source                       res,
	input  logic                            cfg_we,
	input  logic [ltt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ltt_pkg::CFG_W-1:0]       cfg_data
);

	localparam int LIM_W  = ltt_pkg::LIM_W;
	localparam int B_W    = ltt_pkg::MUL_B_W;
	localparam int IDX_W  = ltt_pkg::IDX_W;
	localparam int PW_RAW = TIME_BITS + B_W;
	localparam int PW_CAP = (PW_RAW > 64) ? 64 : PW_RAW;
	localparam int PROD_W = (PW_CAP < LIM_W + 1) ? LIM_W + 1 : PW_CAP;
	localparam int WIDE   = (TIME_BITS > LIM_W) ? TIME_BITS : LIM_W;

	localparam logic [TIME_BITS-1:0] MAXT = '1;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MULL   = 8'b0000_0010,
		ST_DECIDE = 8'b0000_0100,
		ST_DIV    = 8'b0000_1000,
		ST_APPLY  = 8'b0001_0000,
		ST_STOP   = 8'b0010_0000,
		ST_MULF   = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// Registers.
	logic [ltt_pkg::DUR_W-1:0]   dur_q;
	logic [ltt_pkg::LOOPS_W-1:0] loops_q;
	logic                        back_q;

	// Timeline state.
	logic [ltt_pkg::RUN_W-1:0]   mode_q, mode_d;
	logic [TIME_BITS-1:0]        total_q;
	logic [TIME_BITS-1:0]        inloop_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        fin_q, fin_d;

	// Item being worked.
	logic [ltt_pkg::CMD_W-1:0]   cmd_q;
	logic [TIME_BITS-1:0]        tv_q;
	logic [IDX_W-1:0]            old_idx_q;
	logic [LIM_W-1:0]            lim_raw_q;
	logic [TIME_BITS-1:0]        lim_q;
	logic [TIME_BITS-1:0]        msecs_q;

	// Result register.
	logic                        res_valid_q;
	logic [ltt_pkg::RUN_W-1:0]   res_run_q;
	logic [TIME_BITS-1:0]        res_total_q;
	logic [TIME_BITS-1:0]        res_loop_time_q;
	logic [IDX_W-1:0]            res_index_q;
	logic                        res_changed_q;
	logic                        res_fin_q;

	logic                        accept;
	logic                        d_neg, d_zero, d_pos, n_neg, n_zero, bounded;
	logic [ltt_pkg::DMAG_W-1:0]  d_mag;
	logic [ltt_pkg::NMAG_W-1:0]  n_mag;
	logic [WIDE-1:0]             maxt_w, dur_w, lim_w;
	logic [TIME_BITS-1:0]        dclamp, lim_c;
	logic [TIME_BITS:0]          sum;
	logic [TIME_BITS-1:0]        t_add, t_sub, start_r;
	logic                        apply_go;
	logic [TIME_BITS-1:0]        apply_raw, msecs_c;
	logic                        need_prod;

	logic                        mul_start;
	logic [PROD_W-1:0]           mul_a, mul_prod;
	logic [B_W-1:0]              mul_b;
	ltt_pkg::unit_stat_t         mul_stat;

	logic                        div_start;
	logic [TIME_BITS-1:0]        div_quot;
	logic [ltt_pkg::DMAG_W-1:0]  div_rem;
	ltt_pkg::unit_stat_t         div_stat;

	logic                        write_time, load_lim, res_load;
	logic [TIME_BITS-1:0]        q_full, q_adj, cur;
	logic [WIDE-1:0]             rem_w;
	logic [IDX_W-1:0]            idx_new;
	logic                        hit;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);

	// Negative register values act as undefined duration and endless count.
	assign d_neg   = dur_q[ltt_pkg::DUR_W-1];
	assign d_zero  = (dur_q == '0);
	assign d_pos   = !d_neg && !d_zero;
	assign d_mag   = dur_q[ltt_pkg::DMAG_W-1:0];
	assign n_neg   = loops_q[ltt_pkg::LOOPS_W-1];
	assign n_zero  = (loops_q == '0);
	assign n_mag   = loops_q[ltt_pkg::NMAG_W-1:0];
	assign bounded = d_zero || (d_pos && !n_neg);

	assign maxt_w = WIDE'(MAXT);
	assign dur_w  = WIDE'(d_mag);
	assign dclamp = (dur_w > maxt_w) ? MAXT : dur_w[TIME_BITS-1:0];
	assign lim_w  = WIDE'(mul_prod[LIM_W-1:0]);
	assign lim_c  = (lim_w > maxt_w) ? MAXT : lim_w[TIME_BITS-1:0];

	assign sum     = {1'b0, total_q} + {1'b0, tv_q};
	assign t_add   = sum[TIME_BITS] ? MAXT : sum[TIME_BITS-1:0];
	assign t_sub   = (total_q > tv_q) ? (total_q - tv_q) : '0;
	assign start_r = (back_q && d_pos) ? (n_neg ? dclamp : lim_q) : '0;
	assign msecs_c = (bounded && (apply_raw > lim_q)) ? lim_q : apply_raw;

	assign need_prod = !d_neg && !n_neg && !back_q;

	ltt_serial_mul #(
		.A_W (PROD_W),
		.B_W (B_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.stat   (mul_stat)
	);

	ltt_serial_div #(
		.N_W (TIME_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (msecs_c),
		.divisor  (d_mag),
		.quot     (div_quot),
		.rem      (div_rem),
		.stat     (div_stat)
	);

	// Loop index and time within the loop from the division of the new total.
	always_comb begin
		q_full = d_pos ? div_quot : '0;
		rem_w  = WIDE'(div_rem);
		q_adj  = q_full;
		cur    = msecs_q;
		if (!n_neg && (q_full == TIME_BITS'(n_mag))) begin
			cur   = d_pos ? dclamp : '0;
			q_adj = n_zero ? '0 : TIME_BITS'(n_mag - ltt_pkg::NMAG_W'(1));
		end else if (!d_pos) begin
			cur = msecs_q;
		end else if (!back_q) begin
			cur = rem_w[TIME_BITS-1:0];
		end else if (msecs_q == '0) begin
			cur = '0;
		end else if (div_rem == '0) begin
			// Backward play shows a loop boundary as the full duration.
			cur   = dclamp;
			q_adj = q_full - TIME_BITS'(1);
		end else begin
			cur = rem_w[TIME_BITS-1:0];
		end
		idx_new = (q_adj > TIME_BITS'(ltt_pkg::IDX_MAX)) ? ltt_pkg::IDX_MAX : q_adj[IDX_W-1:0];
		hit     = back_q ? (msecs_q == '0) : (bounded && (msecs_q == lim_q));
	end

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		fin_d      = fin_q;
		apply_go   = 1'b0;
		apply_raw  = '0;
		mul_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		div_start  = 1'b0;
		write_time = 1'b0;
		load_lim   = 1'b0;
		res_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mul_start = 1'b1;
					mul_a     = PROD_W'(d_mag);
					mul_b     = B_W'(n_mag);
					state_d   = ST_MULL;
				end
			end
			ST_MULL: begin
				if (mul_stat.done) begin
					load_lim = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_OUT;
				case (cmd_q)
					ltt_pkg::CMD_TICK: begin
						if (mode_q == ltt_pkg::RUN_RUNNING && tv_q != '0) begin
							apply_go  = 1'b1;
							apply_raw = back_q ? t_sub : t_add;
						end
					end
					ltt_pkg::CMD_START: begin
						if (mode_q != ltt_pkg::RUN_RUNNING && !n_zero) begin
							mode_d = ltt_pkg::RUN_RUNNING;
							if (mode_q == ltt_pkg::RUN_STOPPED) begin
								apply_go  = 1'b1;
								apply_raw = start_r;
							end
						end
					end
					ltt_pkg::CMD_STOP: begin
						state_d = ST_STOP;
					end
					ltt_pkg::CMD_PAUSE: begin
						if (mode_q == ltt_pkg::RUN_RUNNING && !n_zero) begin
							mode_d = ltt_pkg::RUN_PAUSED;
						end
					end
					ltt_pkg::CMD_RESUME: begin
						if (mode_q == ltt_pkg::RUN_PAUSED && !n_zero) begin
							mode_d = ltt_pkg::RUN_RUNNING;
						end
					end
					ltt_pkg::CMD_SET: begin
						apply_go  = 1'b1;
						apply_raw = tv_q;
					end
					default: begin
					end
				endcase
				if (apply_go) begin
					div_start = d_pos;
					state_d   = d_pos ? ST_DIV : ST_APPLY;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				write_time = 1'b1;
				state_d    = hit ? ST_STOP : ST_OUT;
			end
			ST_STOP: begin
				state_d = ST_OUT;
				if (mode_q != ltt_pkg::RUN_STOPPED && !n_zero) begin
					mode_d = ltt_pkg::RUN_STOPPED;
					if (need_prod) begin
						// Forward finish compares loop time times loops played
						// against the full length.
						mul_start = 1'b1;
						mul_a     = PROD_W'(inloop_q);
						mul_b     = B_W'(idx_q) + B_W'(1);
						state_d   = ST_MULF;
					end else begin
						fin_d = d_neg || n_neg || (back_q && inloop_q == '0);
					end
				end
			end
			ST_MULF: begin
				if (mul_stat.done) begin
					fin_d   = (mul_prod == PROD_W'(lim_raw_q));
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!res_valid_q || res.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= ltt_pkg::RUN_STOPPED;
			total_q     <= '0;
			inloop_q    <= '0;
			idx_q       <= '0;
			fin_q       <= 1'b0;
			res_valid_q <= 1'b0;
			dur_q       <= '0;
			loops_q     <= ltt_pkg::LOOPS_W'(1);
			back_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			fin_q   <= accept ? 1'b0 : fin_d;
			if (write_time) begin
				total_q  <= msecs_q;
				inloop_q <= cur;
				idx_q    <= idx_new;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					ltt_pkg::CFG_DURATION: dur_q   <= cfg_data[ltt_pkg::DUR_W-1:0];
					ltt_pkg::CFG_LOOPS:    loops_q <= cfg_data[ltt_pkg::LOOPS_W-1:0];
					ltt_pkg::CFG_BACKWARD: back_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd.command;
			tv_q      <= cmd.time_value;
			old_idx_q <= idx_q;
		end
		if (load_lim) begin
			lim_raw_q <= mul_prod[LIM_W-1:0];
			lim_q     <= lim_c;
		end
		if (state_q == ST_DECIDE) begin
			msecs_q <= msecs_c;
		end
		if (res_load) begin
			res_run_q       <= mode_q;
			res_total_q     <= total_q;
			res_loop_time_q <= inloop_q;
			res_index_q     <= idx_q;
			res_changed_q   <= (idx_q != old_idx_q);
			res_fin_q       <= fin_q;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.run_state    = res_run_q;
	assign res.total_time   = res_total_q;
	assign res.loop_time    = res_loop_time_q;
	assign res.loop_index   = res_index_q;
	assign res.loop_changed = res_changed_q;
	assign res.finished     = res_fin_q;

	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == ST_OUT))
		else $error("result item raised outside the output step");

	a_fin_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.finished) |-> (res.run_state == ltt_pkg::RUN_STOPPED))
		else $error("finished reported on a timeline that still runs");

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier restarted while busy");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (!div_stat.busy && state_q == ST_DECIDE))
		else $error("divider restarted while busy");

endmodule

`default_nettype wire

>>> sv/ltt_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ltt_pkg for the status struct.
`default_nettype none

module ltt_serial_mul #(
	parameter int A_W = 57,
	parameter int B_W = ltt_pkg::MUL_B_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [A_W-1:0]      a,
	input  logic [B_W-1:0]      b,
	output logic [A_W-1:0]      prod,
	output ltt_pkg::unit_stat_t stat
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [A_W-1:0]   acc_q;
	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(B_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// The product wraps at A_W bits, which keeps the low bits exact.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (cnt_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[A_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[B_W-1:1]};
		end
	end

	assign prod      = acc_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

`default_nettype wire

>>> sv/ltt_serial_div.sv
// Restoring divider, one quotient bit per cycle, dividend shifted in MSB first.
// Depends on ltt_pkg for the status struct and the divisor width.
`default_nettype none

module ltt_serial_div #(
	parameter int N_W = ltt_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [N_W-1:0]              dividend,
	input  logic [ltt_pkg::DMAG_W-1:0]  divisor,
	output logic [N_W-1:0]              quot,
	output logic [ltt_pkg::DMAG_W-1:0]  rem,
	output ltt_pkg::unit_stat_t         stat
);

	localparam int D_W   = ltt_pkg::DMAG_W;
	localparam int CNT_W = $clog2(N_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   div_q;

	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             ge;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(N_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so its top bit drops.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign quot      = quo_q;
	assign rem       = rem_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

`default_nettype wire
